[rtl/lge_pkg.sv]
// Shared types and constants for the cell grid engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package lge_pkg;

  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int MODE_W      = 3;
  localparam int COORD_W     = 7;
  localparam int OUT_COORD_W = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STEP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIRST = 3'd4;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd5;

  // Neighbour counts of the B3/S23 rule.
  localparam logic [3:0] NB_BIRTH = 4'd3;
  localparam logic [3:0] NB_KEEP  = 4'd2;

  typedef struct packed {
    logic init_wr;
    logic accept;
    logic cell_rd;
    logic cell_fin;
    logic sweep;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic sweep_done;
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

[rtl/lge_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lge_ctrl.sv]
// Controller state machine of the cell grid engine.
// Depends on lge_pkg for the mode codes and the command and status structs.
module lge_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [lge_pkg::MODE_W-1:0] mode,
  output logic                       in_ready,
  input  lge_pkg::sts_t              sts,
  output lge_pkg::cmd_t              cmd
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_ACCESS = 7'b0000100,
    S_CELL   = 7'b0001000,
    S_SWEEP  = 7'b0010000,
    S_SCAN   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_INIT: begin
        if (sts.init_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.init_wr = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (mode)
            lge_pkg::MODE_WRITE, lge_pkg::MODE_READ:  state_next = S_ACCESS;
            lge_pkg::MODE_CLEAR, lge_pkg::MODE_STEP:  state_next = S_SWEEP;
            lge_pkg::MODE_FIRST, lge_pkg::MODE_NEXT:  state_next = S_SCAN;
            default:                                  state_next = S_DONE;
          endcase
        end
      end
      S_ACCESS: begin
        cmd.cell_rd = 1'b1;
        state_next  = S_CELL;
      end
      S_CELL: begin
        cmd.cell_fin = 1'b1;
        state_next   = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // Only one operation is in flight: an accepted word always leaves the idle state.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  a_done_only_from_sweep: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep && sts.sweep_done) |=> (state == S_DONE))
    else $error("sweep finished without reaching the done state");

endmodule

[rtl/lge_dp.sv]
// Datapath of the cell grid engine: configuration registers, row-word RAM,
// three-row window for generation steps, row scanner and result registers.
// Depends on lge_pkg and lge_ram.
module lge_dp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]       cfg_data,
  input  logic [lge_pkg::MODE_W-1:0]      mode,
  input  logic [lge_pkg::COORD_W-1:0]     row,
  input  logic [lge_pkg::COORD_W-1:0]     col,
  input  logic                            alive_in,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            cell_alive,
  output logic                            found,
  output logic [lge_pkg::OUT_COORD_W-1:0] found_row,
  output logic [lge_pkg::OUT_COORD_W-1:0] found_col,
  input  lge_pkg::cmd_t                   cmd,
  output lge_pkg::sts_t                   sts
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int NW  = $clog2(MAX_COLS + 1);
  localparam int SW  = (RW > 8) ? RW : 8;
  localparam int RIW = (AW > lge_pkg::COORD_W) ? AW : lge_pkg::COORD_W;
  localparam int CIW = (CW > lge_pkg::COORD_W) ? CW : lge_pkg::COORD_W;

  // Configuration registers and the clamped sizes taken from them.
  logic [lge_pkg::CFG_W-1:0] rows_cfg, cols_cfg;
  logic [RW-1:0]             nr;
  logic [NW-1:0]             nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= lge_pkg::CFG_RESET;
      cols_cfg <= lge_pkg::CFG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lge_pkg::CFG_ROWS) begin
        rows_cfg <= cfg_data;
      end else begin
        cols_cfg <= cfg_data;
      end
    end
  end

  always_comb begin
    if (rows_cfg == '0) begin
      nr = RW'(1);
    end else if (32'(rows_cfg) > 32'(MAX_ROWS)) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(rows_cfg);
    end
    if (cols_cfg == '0) begin
      nc = NW'(1);
    end else if (32'(cols_cfg) > 32'(MAX_COLS)) begin
      nc = NW'(MAX_COLS);
    end else begin
      nc = NW'(cols_cfg);
    end
  end

  // Latched operation.
  logic [lge_pkg::MODE_W-1:0]  op_mode;
  logic [lge_pkg::COORD_W-1:0] op_row, op_col;
  logic                        op_alive;
  logic                        row_ok, col_ok;
  logic [RIW-1:0]              row_x;
  logic [CIW-1:0]              col_x;
  logic [AW-1:0]               row_addr;
  logic [CW-1:0]               col_idx;

  assign row_ok   = 32'(op_row) < 32'(nr);
  assign col_ok   = 32'(op_col) < 32'(nc);
  assign row_x    = RIW'(op_row);
  assign col_x    = CIW'(op_col);
  assign row_addr = row_x[AW-1:0];
  assign col_idx  = col_x[CW-1:0];

  // Start point of a search, worked out from the port fields at accept time.
  logic [7:0]    col_plus;
  logic [SW-1:0] start_row;
  logic [CW-1:0] start_col;

  always_comb begin
    col_plus  = 8'(col) + 8'd1;
    start_row = '0;
    start_col = '0;
    if (mode == lge_pkg::MODE_NEXT) begin
      if (32'(col_plus) >= 32'(nc)) begin
        start_row = SW'(row) + SW'(1);
      end else begin
        start_row = SW'(row);
        start_col = CW'(col_plus);
      end
    end
  end

  // Counters, window and RAM.
  logic [SW-1:0]       rd_cnt, dr_row, st_row;
  logic [CW-1:0]       st_col;
  logic [RW-1:0]       ld_cnt, wb_cnt;
  logic                rd_vld;
  logic [MAX_COLS-1:0] prev_w, cur_w, q;
  logic                issue, sweep_wr;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata;

  assign issue    = (cmd.sweep || cmd.scan) && (rd_cnt < SW'(nr));
  assign sweep_wr = cmd.sweep && ((rd_vld && (ld_cnt != '0)) ||
                                  (!rd_vld && (ld_cnt == nr) && (wb_cnt != nr)));

  // Column masks: columns in use, and columns at or after the search start.
  logic [MAX_COLS-1:0] col_mask, start_mask;

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i]   = i < int'(nc);
      start_mask[i] = i >= int'(st_col);
    end
  end

  // One generation, or a clear in clear mode, for the row in the middle of the window. The row below
  // is the word arriving from the RAM, or dead once the last row is in.
  logic [MAX_COLS-1:0] nxt_w, life, step_word;
  logic [MAX_COLS+1:0] up_p, md_p, dn_p;
  logic [3:0]          ncount;

  always_comb begin
    ncount = '0;
    nxt_w  = rd_vld ? q : '0;
    up_p   = {1'b0, prev_w & col_mask, 1'b0};
    md_p   = {1'b0, cur_w & col_mask, 1'b0};
    dn_p   = {1'b0, nxt_w & col_mask, 1'b0};
    for (int c = 0; c < MAX_COLS; c++) begin
      ncount = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2]) + 4'(md_p[c]) +
               4'(md_p[c+2]) + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
      life[c] = (ncount == lge_pkg::NB_BIRTH) ||
                (md_p[c+1] && (ncount == lge_pkg::NB_KEEP));
    end
    if (op_mode == lge_pkg::MODE_CLEAR) begin
      step_word = cur_w & ~col_mask;
    end else begin
      step_word = (life & col_mask) | (cur_w & ~col_mask);
    end
  end

  // Scanner: lowest live column of the arriving row.
  logic [MAX_COLS-1:0] scan_w, first_one;
  logic [CW-1:0]       ffs_idx;
  logic                hit;

  always_comb begin
    scan_w    = q & col_mask & ((dr_row == st_row) ? start_mask : '1);
    first_one = scan_w & (~scan_w + MAX_COLS'(1));
    hit       = rd_vld && (|scan_w);
    ffs_idx   = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (first_one[i]) begin
        ffs_idx = ffs_idx | CW'(i);
      end
    end
  end

  // Single-cell update word.
  logic [MAX_COLS-1:0] cell_word;

  always_comb begin
    cell_word          = q;
    cell_word[col_idx] = op_alive;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wb_cnt[AW-1:0];
    ram_wdata = '0;
    priority if (cmd.init_wr) begin
      ram_we = 1'b1;
    end else if (sweep_wr) begin
      ram_we    = 1'b1;
      ram_wdata = step_word;
    end else if (cmd.cell_fin && (op_mode == lge_pkg::MODE_WRITE) && row_ok && col_ok) begin
      ram_we    = 1'b1;
      ram_waddr = row_addr;
      ram_wdata = cell_word;
    end else begin
      ram_we = 1'b0;
    end
    ram_re    = issue || cmd.cell_rd;
    ram_raddr = cmd.cell_rd ? row_addr : rd_cnt[AW-1:0];
  end

  lge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (q)
  );

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      rd_cnt    <= '0;
      ld_cnt    <= '0;
      wb_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= ram_re;
      if (cmd.accept) begin
        rd_cnt <= start_row;
        ld_cnt <= '0;
        wb_cnt <= '0;
      end else begin
        if (issue) begin
          rd_cnt <= rd_cnt + SW'(1);
        end
        if (cmd.sweep && rd_vld) begin
          ld_cnt <= ld_cnt + RW'(1);
        end
        if (sweep_wr || cmd.init_wr) begin
          wb_cnt <= wb_cnt + RW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  logic                            res_cell, res_found;
  logic [lge_pkg::OUT_COORD_W-1:0] res_row, res_col;

  always_ff @(posedge clk) begin
    dr_row <= rd_cnt;
    if (cmd.accept) begin
      op_mode   <= mode;
      op_row    <= row;
      op_col    <= col;
      op_alive  <= alive_in;
      st_row    <= start_row;
      st_col    <= start_col;
      prev_w    <= '0;
      cur_w     <= '0;
      res_cell  <= 1'b0;
      res_found <= 1'b0;
      res_row   <= '0;
      res_col   <= '0;
    end else begin
      if (cmd.sweep && rd_vld) begin
        prev_w <= cur_w;
        cur_w  <= q;
      end
      if (cmd.cell_fin) begin
        res_cell <= (op_mode == lge_pkg::MODE_READ) && row_ok && col_ok && q[col_idx];
      end
      if (cmd.scan && hit) begin
        res_found <= 1'b1;
        res_row   <= lge_pkg::OUT_COORD_W'(dr_row);
        res_col   <= lge_pkg::OUT_COORD_W'(ffs_idx);
      end
    end
    if (cmd.load_out) begin
      cell_alive <= res_cell;
      found      <= res_found;
      found_row  <= res_row;
      found_col  <= res_col;
    end
  end

  assign sts.init_done  = wb_cnt == RW'(MAX_ROWS);
  assign sts.sweep_done = wb_cnt == nr;
  assign sts.scan_done  = hit || (!rd_vld && (rd_cnt >= SW'(nr)));
  assign sts.out_busy   = out_valid && !out_ready;

  // Outside the clearing pass, rows beyond the area in use are never written.
  a_write_in_area: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !cmd.init_wr) |-> (32'(ram_waddr) < 32'(nr)))
    else $error("grid row written outside the area in use");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result word overwritten before it was taken");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> (wb_cnt <= ld_cnt))
    else $error("row written back before it was loaded");

endmodule

[rtl/life_grid_engine_top.sv]
// Cell grid engine (B3/S23). One operation word at a time: cell read or write, clear,
// generation step or search; an unused mode only returns a result. A search reads one
// RAM row word per cycle. The next word can be taken in the same cycle as out_valid rises;
// a new result is then held back while the previous one waits.
// After reset a clearing pass writes all MAX_ROWS rows dead (no input taken);
// rows_in_use and cols_in_use reset to 64.
module life_grid_engine_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lge_pkg::MODE_W-1:0]      mode,
  input  logic [lge_pkg::COORD_W-1:0]     row,
  input  logic [lge_pkg::COORD_W-1:0]     col,
  input  logic                            alive_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            cell_alive,
  output logic                            found,
  output logic [lge_pkg::OUT_COORD_W-1:0] found_row,
  output logic [lge_pkg::OUT_COORD_W-1:0] found_col
);

  lge_pkg::cmd_t cmd;
  lge_pkg::sts_t sts;

  lge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lge_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .row        (row),
    .col        (col),
    .alive_in   (alive_in),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .cell_alive (cell_alive),
    .found      (found),
    .found_row  (found_row),
    .found_col  (found_col),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
